[sv/txfsa_pkg.sv]
// Package for the transmit arbiter: transaction payload types, item kind codes
// and the command and status structs between controller and datapath.
// No dependencies.
package txfsa_pkg;

    localparam logic [1:0] KIND_PUSH       = 2'd0;
    localparam logic [1:0] KIND_STAT_WRITE = 2'd1;
    localparam logic [1:0] KIND_STAT_START = 2'd2;
    localparam logic [1:0] KIND_TICK       = 2'd3;

    localparam logic RES_BYTE    = 1'b0;
    localparam logic RES_REFUSED = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [9:0]  status_index;
        logic [10:0] status_length;
        logic        sink_ready;
    } t_item;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] out_byte;
        logic       from_status;
        logic       last_in_chunk;
        logic       status_done;
    } t_result;

    typedef struct packed {
        logic push;
        logic refuse;
        logic stat_write;
        logic stat_start;
        logic fifo_emit;
        logic stat_emit;
        logic last;
        logic done;
        logic pos_clear;
        logic pend_clear;
    } t_dp_cmd;

    typedef struct packed {
        logic gate_ok;
        logic fifo_empty;
        logic fifo_full;
        logic fifo_one;
        logic pending;
        logic stat_none;
        logic stat_last;
    } t_dp_stat;

endpackage

[sv/txfsa_dp.sv]
// Datapath of the transmit arbiter: byte FIFO, status buffer, their pointers
// and counts, the sink gate register and the result register.
// Depends on txfsa_pkg.
module txfsa_dp #(
    parameter int FIFO_DEPTH   = 1024,
    parameter int STATUS_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  txfsa_pkg::t_item   i_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  txfsa_pkg::t_dp_cmd i_cmd,
    output txfsa_pkg::t_dp_stat o_stat,
    output logic               o_strobe,
    output txfsa_pkg::t_result o_result
);
    import txfsa_pkg::*;

    localparam int FAW = $clog2(FIFO_DEPTH);
    localparam int FCW = $clog2(FIFO_DEPTH + 1);
    localparam int SAW = $clog2(STATUS_DEPTH);
    localparam int SCW = $clog2(STATUS_DEPTH + 1);

    logic [7:0] r_fifo_mem [FIFO_DEPTH];
    logic [7:0] r_stat_mem [STATUS_DEPTH];

    logic           r_gate;
    logic [FAW-1:0] r_head, n_head;
    logic [FAW-1:0] r_tail, n_tail;
    logic [FCW-1:0] r_fcount, n_fcount;
    logic [SCW-1:0] r_scount, n_scount;
    logic [SCW-1:0] r_spos, n_spos;
    logic           r_pending, n_pending;
    logic           r_strobe;
    t_result        r_result;
    logic [SCW:0]   pos_inc;
    logic           idx_ok;

    assign pos_inc = {1'b0, r_spos} + (SCW + 1)'(1);
    assign idx_ok  = 32'(i_item.status_index) < STATUS_DEPTH;

    always_comb begin
        o_stat.gate_ok    = !r_gate || i_item.sink_ready;
        o_stat.fifo_empty = r_fcount == '0;
        o_stat.fifo_full  = r_fcount == FCW'(FIFO_DEPTH);
        o_stat.fifo_one   = r_fcount == FCW'(1);
        o_stat.pending    = r_pending;
        o_stat.stat_none  = r_spos >= r_scount;
        o_stat.stat_last  = pos_inc >= {1'b0, r_scount};
    end

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_fcount  = r_fcount;
        n_scount  = r_scount;
        n_spos    = r_spos;
        n_pending = r_pending;
        if (i_cmd.push) begin
            n_tail   = (r_tail == FAW'(FIFO_DEPTH - 1)) ? '0 : r_tail + FAW'(1);
            n_fcount = r_fcount + FCW'(1);
        end
        if (i_cmd.fifo_emit) begin
            n_head   = (r_head == FAW'(FIFO_DEPTH - 1)) ? '0 : r_head + FAW'(1);
            n_fcount = r_fcount - FCW'(1);
        end
        if (i_cmd.stat_start) begin
            n_scount  = (32'(i_item.status_length) > STATUS_DEPTH) ?
                        SCW'(STATUS_DEPTH) : SCW'(i_item.status_length);
            n_pending = 1'b1;
        end
        if (i_cmd.pos_clear) begin
            n_spos = '0;
        end
        if (i_cmd.stat_emit) begin
            n_spos = pos_inc[SCW-1:0];
        end
        if (i_cmd.pend_clear) begin
            n_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate    <= 1'b1;
            r_head    <= '0;
            r_tail    <= '0;
            r_fcount  <= '0;
            r_scount  <= '0;
            r_spos    <= '0;
            r_pending <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gate <= i_cfg_wdata;
            end
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_fcount  <= n_fcount;
            r_scount  <= n_scount;
            r_spos    <= n_spos;
            r_pending <= n_pending;
            r_strobe  <= i_cmd.refuse || i_cmd.fifo_emit || i_cmd.stat_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_fifo_mem[r_tail] <= i_item.data_byte;
        end
        if (i_cmd.stat_write && idx_ok) begin
            r_stat_mem[SAW'(i_item.status_index)] <= i_item.data_byte;
        end
        if (i_cmd.stat_emit) begin
            r_result.out_byte <= r_stat_mem[r_spos[SAW-1:0]];
        end else if (i_cmd.fifo_emit) begin
            r_result.out_byte <= r_fifo_mem[r_head];
        end else begin
            r_result.out_byte <= '0;
        end
        r_result.result_kind   <= i_cmd.refuse ? RES_REFUSED : RES_BYTE;
        r_result.from_status   <= i_cmd.stat_emit;
        r_result.last_in_chunk <= i_cmd.last;
        r_result.status_done   <= i_cmd.done;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

[sv/txfsa_ctrl.sv]
// Controller of the transmit arbiter: the idle, delay and status transmit
// arbiter state and the sequencer that emits one byte per cycle of a chunk.
// Depends on txfsa_pkg.
module txfsa_ctrl #(
    parameter int CHUNK_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_kind,
    input  txfsa_pkg::t_dp_stat i_stat,
    output logic                o_busy,
    output txfsa_pkg::t_dp_cmd  o_cmd
);
    import txfsa_pkg::*;

    localparam int CNW = $clog2(CHUNK_BYTES + 1);

    typedef enum logic [1:0] {SQ_IDLE, SQ_FIFO, SQ_STAT} t_seq;
    typedef enum logic [1:0] {AR_IDLE, AR_DELAY, AR_STATUS_TX} t_arb;

    t_seq           r_sq, n_sq;
    t_arb           r_ar, n_ar;
    logic [CNW-1:0] r_cnt, n_cnt;
    logic           r_busy;
    logic [CNW-1:0] cur_cnt;
    logic           chunk_end;
    logic           accept;
    t_dp_cmd        cmd;

    assign accept    = i_start && !r_busy;
    assign cur_cnt   = (r_sq == SQ_IDLE) ? '0 : r_cnt;
    assign chunk_end = cur_cnt == CNW'(CHUNK_BYTES - 1);

    always_comb begin
        n_sq  = r_sq;
        n_ar  = r_ar;
        n_cnt = r_cnt;
        cmd   = '0;
        unique case (r_sq)
            SQ_IDLE: begin
                if (accept) begin
                    unique case (i_kind)
                        KIND_PUSH: begin
                            cmd.refuse = i_stat.fifo_full;
                            cmd.push   = !i_stat.fifo_full;
                        end
                        KIND_STAT_WRITE: cmd.stat_write = 1'b1;
                        KIND_STAT_START: cmd.stat_start = 1'b1;
                        KIND_TICK: begin
                            if (i_stat.gate_ok) begin
                                unique case (r_ar)
                                    AR_IDLE: begin
                                        if (!i_stat.fifo_empty) begin
                                            cmd.fifo_emit = 1'b1;
                                            cmd.last      = chunk_end || i_stat.fifo_one;
                                            n_cnt         = cur_cnt + CNW'(1);
                                            n_sq          = cmd.last ? SQ_IDLE : SQ_FIFO;
                                        end else if (i_stat.pending) begin
                                            n_ar          = AR_DELAY;
                                            cmd.pos_clear = 1'b1;
                                        end
                                    end
                                    AR_DELAY: begin
                                        n_ar = i_stat.fifo_empty ? AR_STATUS_TX : AR_IDLE;
                                    end
                                    AR_STATUS_TX: begin
                                        if (i_stat.stat_none) begin
                                            cmd.pend_clear = 1'b1;
                                            n_ar           = AR_IDLE;
                                        end else begin
                                            cmd.stat_emit = 1'b1;
                                            cmd.done      = i_stat.stat_last;
                                            cmd.last      = i_stat.stat_last || chunk_end;
                                            cmd.pend_clear = i_stat.stat_last;
                                            n_ar          = i_stat.stat_last ? AR_IDLE : r_ar;
                                            n_cnt         = cur_cnt + CNW'(1);
                                            n_sq          = cmd.last ? SQ_IDLE : SQ_STAT;
                                        end
                                    end
                                    default: n_ar = AR_IDLE;
                                endcase
                            end
                        end
                    endcase
                end
            end
            SQ_FIFO: begin
                cmd.fifo_emit = 1'b1;
                cmd.last      = chunk_end || i_stat.fifo_one;
                n_cnt         = cur_cnt + CNW'(1);
                n_sq          = cmd.last ? SQ_IDLE : SQ_FIFO;
            end
            SQ_STAT: begin
                cmd.stat_emit  = 1'b1;
                cmd.done       = i_stat.stat_last;
                cmd.last       = i_stat.stat_last || chunk_end;
                cmd.pend_clear = i_stat.stat_last;
                n_ar           = i_stat.stat_last ? AR_IDLE : r_ar;
                n_cnt          = cur_cnt + CNW'(1);
                n_sq           = cmd.last ? SQ_IDLE : SQ_STAT;
            end
            default: n_sq = SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq   <= SQ_IDLE;
            r_ar   <= AR_IDLE;
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_sq   <= n_sq;
            r_ar   <= n_ar;
            r_cnt  <= n_cnt;
            r_busy <= n_sq != SQ_IDLE;
        end
    end

    assign o_busy = r_busy;
    assign o_cmd  = cmd;

    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.fifo_emit && cmd.stat_emit))
        else $error("FIFO and status buffer emitted in the same cycle.");

    a_fifo_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq == SQ_FIFO |-> !i_stat.fifo_empty)
        else $error("FIFO drain continued past an empty FIFO.");

    a_stat_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq == SQ_STAT |-> !i_stat.stat_none && r_ar == AR_STATUS_TX)
        else $error("Status drain continued without bytes left.");

    a_busy_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.last && (cmd.fifo_emit || cmd.stat_emit) |=> !r_busy)
        else $error("Sequencer stayed busy after the last byte of a chunk.");

endmodule

[sv/tx_fifo_statusbar_arbiter_top.sv]
// Top level of the terminal transmit arbiter: joins controller and datapath.
// Depends on txfsa_pkg, txfsa_ctrl and txfsa_dp.
//
//   Channel   Handshake              Payload
//   command   start / busy           i_item   (txfsa_pkg::t_item)
//   result    o_strobe, no stall     o_result (txfsa_pkg::t_result)
//   config    i_cfg_we               i_cfg_wdata (sink_gate_enable)
//
// A push, status write or status start leaves busy low; a refused push shows
// its result in the next cycle. A service tick that emits n bytes holds busy
// while its later bytes are emitted, one byte per cycle from the memory read
// port, and its results come from a result register. Other ticks leave busy low.
// Synchronous active-low reset clears pointers, counts and state; the
// memories are not cleared. The receiver cannot stall a result.
module tx_fifo_statusbar_arbiter_top #(
    parameter int FIFO_DEPTH   = 1024,
    parameter int STATUS_DEPTH = 1024,
    parameter int CHUNK_BYTES  = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  txfsa_pkg::t_item   i_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    output logic               o_strobe,
    output txfsa_pkg::t_result o_result
);
    import txfsa_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    txfsa_ctrl #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_kind (i_item.kind),
        .i_stat (stat),
        .o_busy (busy),
        .o_cmd  (cmd)
    );

    txfsa_dp #(
        .FIFO_DEPTH  (FIFO_DEPTH),
        .STATUS_DEPTH(STATUS_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule
